FILE: design/edge_shade_and_blend_pixel_macros.svh
// Assertion macros for the edge shade and blend pixel block.
// Used by design files that carry concurrent checks; expects clk and rst in scope.
`ifndef EDGE_SHADE_AND_BLEND_PIXEL_MACROS_SVH
`define EDGE_SHADE_AND_BLEND_PIXEL_MACROS_SVH

// same-cycle implication
`define ESB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ESB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: design/esb_pkg.sv
// Shared types, constants and channel tables for edge shade and blend.
// No dependencies; used by every module of the block.
package esb_pkg;

  localparam int MAX_SIDE = 256;
  localparam int SIDE_W   = $clog2(MAX_SIDE + 1);   // width of a clipped frame side

  typedef logic [5:0] pix_t;
  localparam pix_t WHITE_PIX = 6'd63;

  typedef enum logic [1:0] {
    REG_BG     = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // per-cell control for pass one
  typedef struct packed {
    logic in_frame;
    logic keep;      // on row 0 or column 0
  } cell_ctl_t;

  // masked original pixels around the 2x2 block
  typedef struct packed {
    pix_t up_0;
    pix_t up_1;
    pix_t ra_0;
    pix_t ra_1;
    pix_t ra_2;
    pix_t ra_3;
    pix_t rb_0;
    pix_t rb_1;
    pix_t rb_2;
    pix_t rb_3;
    pix_t dn_0;
    pix_t dn_1;
  } window_t;

  // channel*85/3 >> 6: only full intensity survives, as 1
  function automatic logic [1:0] shade_side(input logic [1:0] ch);
    return (ch == 2'd3) ? 2'd1 : 2'd0;
  endfunction

  // channel*85/2 >> 6: 2 and 3 map to 1
  function automatic logic [1:0] shade_bottom(input logic [1:0] ch);
    return {1'b0, ch[1]};
  endfunction

  // (sum*85/8) >> 6 equals (sum*85) >> 9
  function automatic logic [1:0] blend_quant(input logic [4:0] sum);
    logic [11:0] prod;
    prod = 12'(sum) * 12'd85;
    return prod[10:9];
  endfunction

endpackage

FILE: design/edge_shade_and_blend_pixel.sv
// Edge shade and blend, top level: APB registers, input register, pass one, blend.
// Pipeline: the input register, then the result register, which drives pixel_out.
// Throughput: one pixel per clock while out_ready does not stall; one combinational pass between the two registers.
// Backpressure from out_ready reaches in_ready combinationally through the stage enables.
// Reset (rst, synchronous): pipeline empty, background_color 0, width 144, height 168.
// Depends on esb_pkg, esb_window, esb_cell, esb_blend and the macros header.
`include "edge_shade_and_blend_pixel_macros.svh"

module edge_shade_and_blend_pixel (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  row_index,
  input  logic [7:0]  col_index,
  input  logic [11:0] window_above,
  input  logic [23:0] window_row_a,
  input  logic [23:0] window_row_b,
  input  logic [11:0] window_below,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  pixel_out
);

  // configuration registers
  esb_pkg::pix_t      background_color;
  logic [8:0]         frame_width;
  logic [8:0]         frame_height;
  esb_pkg::reg_idx_t  reg_sel;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = esb_pkg::reg_idx_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      background_color <= '0;
      frame_width      <= 9'd144;
      frame_height     <= 9'd168;
    end else if (cfg_write) begin
      case (reg_sel)
        esb_pkg::REG_BG:     background_color <= pwdata[5:0];
        esb_pkg::REG_WIDTH:  frame_width      <= pwdata[8:0];
        esb_pkg::REG_HEIGHT: frame_height     <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      esb_pkg::REG_BG:     prdata = {26'd0, background_color};
      esb_pkg::REG_WIDTH:  prdata = {23'd0, frame_width};
      esb_pkg::REG_HEIGHT: prdata = {23'd0, frame_height};
      default:             prdata = '0;
    endcase
  end

  // sides above MAX_SIDE act as MAX_SIDE
  logic [esb_pkg::SIDE_W-1:0] lim_w;
  logic [esb_pkg::SIDE_W-1:0] lim_h;

  assign lim_w = (32'(frame_width) > esb_pkg::MAX_SIDE) ?
                 esb_pkg::SIDE_W'(esb_pkg::MAX_SIDE) : esb_pkg::SIDE_W'(frame_width);
  assign lim_h = (32'(frame_height) > esb_pkg::MAX_SIDE) ?
                 esb_pkg::SIDE_W'(esb_pkg::MAX_SIDE) : esb_pkg::SIDE_W'(frame_height);

  // input register stage
  logic        held;
  logic [7:0]  row_idx;
  logic [7:0]  col_idx;
  logic [11:0] above;
  logic [23:0] row_a;
  logic [23:0] row_b;
  logic [11:0] below;
  logic        out_free;
  logic        advance;

  assign out_free = !out_valid || out_ready;
  assign advance  = held && out_free;
  assign in_ready = !held || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      row_idx <= row_index;
      col_idx <= col_index;
      above   <= window_above;
      row_a   <= window_row_a;
      row_b   <= window_row_b;
      below   <= window_below;
    end
  end

  // combinational pass
  esb_pkg::window_t   win;
  esb_pkg::cell_ctl_t ctl_11;
  esb_pkg::cell_ctl_t ctl_12;
  esb_pkg::cell_ctl_t ctl_21;
  esb_pkg::cell_ctl_t ctl_22;
  logic               last_row;
  esb_pkg::pix_t      p11;
  esb_pkg::pix_t      p12;
  esb_pkg::pix_t      p21;
  esb_pkg::pix_t      p22;
  esb_pkg::pix_t      pixel_next;

  esb_window u_window (
    .row_index    (row_idx),
    .col_index    (col_idx),
    .window_above (above),
    .window_row_a (row_a),
    .window_row_b (row_b),
    .window_below (below),
    .lim_w        (lim_w),
    .lim_h        (lim_h),
    .win          (win),
    .ctl_11       (ctl_11),
    .ctl_12       (ctl_12),
    .ctl_21       (ctl_21),
    .ctl_22       (ctl_22),
    .last_row     (last_row)
  );

  esb_cell u_cell_11 (
    .cur (win.ra_1), .up (win.up_0), .left (win.ra_0), .right (win.ra_2),
    .down (win.rb_1), .ctl (ctl_11), .bg (background_color), .shaded (p11)
  );

  esb_cell u_cell_12 (
    .cur (win.ra_2), .up (win.up_1), .left (win.ra_1), .right (win.ra_3),
    .down (win.rb_2), .ctl (ctl_12), .bg (background_color), .shaded (p12)
  );

  esb_cell u_cell_21 (
    .cur (win.rb_1), .up (win.ra_1), .left (win.rb_0), .right (win.rb_2),
    .down (win.dn_0), .ctl (ctl_21), .bg (background_color), .shaded (p21)
  );

  esb_cell u_cell_22 (
    .cur (win.rb_2), .up (win.ra_2), .left (win.rb_1), .right (win.rb_3),
    .down (win.dn_1), .ctl (ctl_22), .bg (background_color), .shaded (p22)
  );

  esb_blend u_blend (
    .p        (p11),
    .s        (p12),
    .b        (p21),
    .d        (p22),
    .frame_ok (ctl_11.in_frame),
    .last_row (last_row),
    .blended  (pixel_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= held;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_out <= pixel_next;
    end
  end

  `ESB_ASSERT_NEXT(a_held_kept, held && !out_free, held)
  `ESB_ASSERT_NEXT(a_advance_valid, advance, out_valid)
  `ESB_ASSERT_NEXT(a_outside_black, advance && !ctl_11.in_frame, pixel_out == 6'd0)
  `ESB_ASSERT_NOW(a_empty_ready, !held, in_ready)

endmodule

FILE: design/esb_window.sv
// Frame-edge masking of the input window and per-cell control flags.
// Depends on esb_pkg.
module esb_window (
  input  logic [7:0]                    row_index,
  input  logic [7:0]                    col_index,
  input  logic [11:0]                   window_above,
  input  logic [23:0]                   window_row_a,
  input  logic [23:0]                   window_row_b,
  input  logic [11:0]                   window_below,
  input  logic [esb_pkg::SIDE_W-1:0]    lim_w,
  input  logic [esb_pkg::SIDE_W-1:0]    lim_h,
  output esb_pkg::window_t              win,
  output esb_pkg::cell_ctl_t            ctl_11,
  output esb_pkg::cell_ctl_t            ctl_12,
  output esb_pkg::cell_ctl_t            ctl_21,
  output esb_pkg::cell_ctl_t            ctl_22,
  output logic                          last_row
);

  logic [3:0] row_ok;
  logic [3:0] col_ok;

  // offsets -1..+2; row -1 wraps to all ones and fails the compare
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      row_ok[i] = (10'({2'b00, row_index} + 10'(i) - 10'd1) < 10'(lim_h));
      col_ok[i] = (10'({2'b00, col_index} + 10'(i) - 10'd1) < 10'(lim_w));
    end
  end

  always_comb begin
    win.up_0 = (row_ok[0] && col_ok[1]) ? window_above[11:6] : '0;
    win.up_1 = (row_ok[0] && col_ok[2]) ? window_above[5:0]  : '0;
    win.ra_0 = (row_ok[1] && col_ok[0]) ? window_row_a[23:18] : '0;
    win.ra_1 = (row_ok[1] && col_ok[1]) ? window_row_a[17:12] : '0;
    win.ra_2 = (row_ok[1] && col_ok[2]) ? window_row_a[11:6]  : '0;
    win.ra_3 = (row_ok[1] && col_ok[3]) ? window_row_a[5:0]   : '0;
    win.rb_0 = (row_ok[2] && col_ok[0]) ? window_row_b[23:18] : '0;
    win.rb_1 = (row_ok[2] && col_ok[1]) ? window_row_b[17:12] : '0;
    win.rb_2 = (row_ok[2] && col_ok[2]) ? window_row_b[11:6]  : '0;
    win.rb_3 = (row_ok[2] && col_ok[3]) ? window_row_b[5:0]   : '0;
    win.dn_0 = (row_ok[3] && col_ok[1]) ? window_below[11:6] : '0;
    win.dn_1 = (row_ok[3] && col_ok[2]) ? window_below[5:0]  : '0;
  end

  assign ctl_11.in_frame = row_ok[1] && col_ok[1];
  assign ctl_11.keep     = (row_index == 8'd0) || (col_index == 8'd0);
  assign ctl_12.in_frame = row_ok[1] && col_ok[2];
  assign ctl_12.keep     = (row_index == 8'd0);
  assign ctl_21.in_frame = row_ok[2] && col_ok[1];
  assign ctl_21.keep     = (col_index == 8'd0);
  assign ctl_22.in_frame = row_ok[2] && col_ok[2];
  assign ctl_22.keep     = 1'b0;

  // lim_h of zero gives all ones here, never matched by an 8-bit row
  assign last_row = ({1'b0, row_index} == (lim_h - esb_pkg::SIDE_W'(1)));

endmodule

FILE: design/esb_cell.sv
// Pass-one shading of a single pixel from its four masked neighbors.
// Depends on esb_pkg.
module esb_cell (
  input  esb_pkg::pix_t      cur,
  input  esb_pkg::pix_t      up,
  input  esb_pkg::pix_t      left,
  input  esb_pkg::pix_t      right,
  input  esb_pkg::pix_t      down,
  input  esb_pkg::cell_ctl_t ctl,
  input  esb_pkg::pix_t      bg,
  output esb_pkg::pix_t      shaded
);

  always_comb begin
    if (!ctl.in_frame) begin
      shaded = '0;
    end else if (ctl.keep || cur == esb_pkg::WHITE_PIX) begin
      shaded = cur;
    end else if (up == esb_pkg::WHITE_PIX) begin
      shaded = '0;   // /5 darkening leaves nothing of a 2-bit channel
    end else if (left == esb_pkg::WHITE_PIX || right == esb_pkg::WHITE_PIX) begin
      shaded = {esb_pkg::shade_side(cur[5:4]), esb_pkg::shade_side(cur[3:2]),
                esb_pkg::shade_side(cur[1:0])};
    end else if (down == esb_pkg::WHITE_PIX) begin
      shaded = {esb_pkg::shade_bottom(cur[5:4]), esb_pkg::shade_bottom(cur[3:2]),
                esb_pkg::shade_bottom(cur[1:0])};
    end else begin
      shaded = bg;
    end
  end

endmodule

FILE: design/esb_blend.sv
// Pass-two 3/2/2/1 weighted blend over the pass-one 2x2 block; black outside the frame, p on the last row.
// Depends on esb_pkg.
module esb_blend (
  input  esb_pkg::pix_t p,
  input  esb_pkg::pix_t s,
  input  esb_pkg::pix_t b,
  input  esb_pkg::pix_t d,
  input  logic          frame_ok,
  input  logic          last_row,
  output esb_pkg::pix_t blended
);

  logic [4:0]    sum [3];
  esb_pkg::pix_t mix;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = 5'(p[2*c +: 2]) * 5'd3 + 5'(s[2*c +: 2]) * 5'd2
             + 5'(b[2*c +: 2]) * 5'd2 + 5'(d[2*c +: 2]);
      mix[2*c +: 2] = esb_pkg::blend_quant(sum[c]);
    end
  end

  always_comb begin
    if (!frame_ok) begin
      blended = '0;
    end else if (last_row) begin
      blended = p;
    end else begin
      blended = mix;
    end
  end

endmodule
